// ===== hdl/ttid_pkg.sv =====
// Shared types, constants and codes for the timer table with id allocation.
`default_nettype none
package ttid_pkg;

	localparam int MAX_TIMERS   = 16;
	localparam int RESULT_LIMIT = 16;
	localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
	localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int NCNT_W = $clog2(RESULT_LIMIT + 1);
	localparam int TIME_W  = 48;
	localparam int DELAY_W = 32;
	localparam int ID_W    = 16;
	localparam int SHORT_W = 32;
	localparam logic [TIME_W-1:0] SHORTEST_SAT = TIME_W'(32'h7FFF_FFFF);

	typedef enum logic [1:0] {
		MODE_SET    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_POLL   = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET_RD,
		ST_SET_EV,
		ST_SET_WR,
		ST_CMP_RD,
		ST_CMP_EV,
		ST_QRY_RD,
		ST_QRY_EV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] alarm;
		logic [ID_W-1:0]   id;
	} entry_t;

	typedef struct packed {
		logic                      status;
		logic [ID_W-1:0]           result_id;
		logic                      expired;
		logic signed [SHORT_W-1:0] shortest_ms;
		logic                      last;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/ttid_mem.sv =====
// Timer entry memory: one write port, one registered read port.
`default_nettype none
module ttid_mem (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [ttid_pkg::IDX_W-1:0] waddr,
	input  wire ttid_pkg::entry_t        wdata,
	input  wire logic                    re,
	input  wire logic [ttid_pkg::IDX_W-1:0] raddr,
	output ttid_pkg::entry_t             rdata
);

	ttid_pkg::entry_t mem [ttid_pkg::MAX_TIMERS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ttid_ctrl.sv =====
// Sequencer that walks the timer memory for set, remove, poll and query.
`default_nettype none
module ttid_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    mode,
	input  wire logic [ttid_pkg::TIME_W-1:0]   now_ms,
	input  wire logic [ttid_pkg::DELAY_W-1:0]  delay_ms,
	input  wire logic [ttid_pkg::ID_W-1:0]     request_id,
	output logic                               res_valid,
	output ttid_pkg::result_t                  res,
	input  wire logic                          res_take
);

	ttid_pkg::state_t st_q, st_d;
	logic [ttid_pkg::CNT_W-1:0]  cnt_q, cnt_d, r_q, r_d, w_q, w_d;
	logic [ttid_pkg::NCNT_W-1:0] n_q, n_d;
	logic [ttid_pkg::ID_W-1:0]   ctr_q, ctr_d, cand_q, cand_d, pend_id_q, pend_id_d;
	logic [ttid_pkg::ID_W-1:0]   req_q, req_d;
	logic                        found_q, found_d, pend_q, pend_d;
	logic                        poll_q, poll_d;
	logic [ttid_pkg::TIME_W-1:0] now_q, now_d, alarm_q, alarm_d, short_q, short_d;
	ttid_pkg::result_t           res_q, res_d;

	logic                        mem_we, mem_re;
	logic [ttid_pkg::IDX_W-1:0]  mem_waddr, mem_raddr;
	ttid_pkg::entry_t            mem_wdata, rdata;

	logic [ttid_pkg::TIME_W:0]   sum;
	logic [ttid_pkg::TIME_W-1:0] diff, val;
	logic                        due, drop, at_end, hold;
	logic [ttid_pkg::CNT_W-1:0]  r_inc, w_inc;

	ttid_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	assign sum   = {1'b0, now_ms} + {{(ttid_pkg::TIME_W + 1 - ttid_pkg::DELAY_W){1'b0}}, delay_ms};
	assign due   = (rdata.alarm <= now_q);
	assign diff  = rdata.alarm - now_q;
	assign val   = due ? '0 : ((diff > ttid_pkg::SHORTEST_SAT) ? ttid_pkg::SHORTEST_SAT : diff);
	assign r_inc = r_q + ttid_pkg::CNT_W'(1);
	assign w_inc = w_q + ttid_pkg::CNT_W'(1);
	assign at_end = (r_inc == cnt_q);
	assign drop  = poll_q ? (due && (n_q < ttid_pkg::NCNT_W'(ttid_pkg::RESULT_LIMIT)))
	                      : ((rdata.id == req_q) && !found_q);
	// a new due timer must first push out the one held back
	assign hold  = poll_q && drop && pend_q && !res_take;

	// next state
	always_comb begin
		st_d      = st_q;
		cnt_d     = cnt_q;
		r_d       = r_q;
		w_d       = w_q;
		n_d       = n_q;
		ctr_d     = ctr_q;
		cand_d    = cand_q;
		pend_id_d = pend_id_q;
		req_d     = req_q;
		found_d   = found_q;
		pend_d    = pend_q;
		poll_d    = poll_q;
		now_d     = now_q;
		alarm_d   = alarm_q;
		short_d   = short_q;
		res_d     = res_q;
		case (st_q)
			ttid_pkg::ST_IDLE: begin
				if (in_valid) begin
					res_d   = '0;
					res_d.last = 1'b1;
					now_d   = now_ms;
					req_d   = request_id;
					r_d     = '0;
					w_d     = '0;
					n_d     = '0;
					found_d = 1'b0;
					pend_d  = 1'b0;
					poll_d  = (mode == ttid_pkg::MODE_POLL);
					short_d = ttid_pkg::SHORTEST_SAT;
					case (mode)
						ttid_pkg::MODE_SET: begin
							alarm_d = sum[ttid_pkg::TIME_W] ? '1 : sum[ttid_pkg::TIME_W-1:0];
							cand_d  = ctr_q + ttid_pkg::ID_W'(1);
							if (cnt_q >= ttid_pkg::CNT_W'(ttid_pkg::MAX_TIMERS)) begin
								res_d.status = 1'b1;
								st_d = ttid_pkg::ST_EMIT;
							end else if (cnt_q == '0) begin
								st_d = ttid_pkg::ST_SET_WR;
							end else begin
								st_d = ttid_pkg::ST_SET_RD;
							end
						end
						ttid_pkg::MODE_QUERY: begin
							if (cnt_q == '0) begin
								res_d.shortest_ms = '1;
								st_d = ttid_pkg::ST_EMIT;
							end else begin
								st_d = ttid_pkg::ST_QRY_RD;
							end
						end
						default: begin
							st_d = (cnt_q == '0) ? ttid_pkg::ST_EMIT : ttid_pkg::ST_CMP_RD;
						end
					endcase
				end
			end
			ttid_pkg::ST_SET_RD: st_d = ttid_pkg::ST_SET_EV;
			ttid_pkg::ST_SET_EV: begin
				if (rdata.id == cand_q) begin
					// id taken: try the next one from the top of the table
					cand_d = cand_q + ttid_pkg::ID_W'(1);
					r_d    = '0;
					st_d   = ttid_pkg::ST_SET_RD;
				end else if (at_end) begin
					st_d = ttid_pkg::ST_SET_WR;
				end else begin
					r_d  = r_inc;
					st_d = ttid_pkg::ST_SET_RD;
				end
			end
			ttid_pkg::ST_SET_WR: begin
				cnt_d = cnt_q + ttid_pkg::CNT_W'(1);
				ctr_d = cand_q;
				res_d.result_id = cand_q;
				st_d  = ttid_pkg::ST_EMIT;
			end
			ttid_pkg::ST_CMP_RD: st_d = ttid_pkg::ST_CMP_EV;
			ttid_pkg::ST_CMP_EV: begin
				if (!hold) begin
					if (drop) begin
						found_d = 1'b1;
						if (poll_q) begin
							pend_d    = 1'b1;
							pend_id_d = rdata.id;
							n_d       = n_q + ttid_pkg::NCNT_W'(1);
						end
					end else begin
						w_d = w_inc;
					end
					r_d = r_inc;
					if (at_end) begin
						cnt_d = drop ? w_q : w_inc;
						res_d = '0;
						res_d.last = 1'b1;
						if (pend_d) begin
							res_d.result_id = pend_id_d;
							res_d.expired   = 1'b1;
						end
						st_d = ttid_pkg::ST_EMIT;
					end else begin
						st_d = ttid_pkg::ST_CMP_RD;
					end
				end
			end
			ttid_pkg::ST_QRY_RD: st_d = ttid_pkg::ST_QRY_EV;
			ttid_pkg::ST_QRY_EV: begin
				if (val < short_q) begin
					short_d = val;
				end
				r_d = r_inc;
				if (at_end) begin
					res_d.shortest_ms = short_d[ttid_pkg::SHORT_W-1:0];
					st_d = ttid_pkg::ST_EMIT;
				end else begin
					st_d = ttid_pkg::ST_QRY_RD;
				end
			end
			ttid_pkg::ST_EMIT: begin
				if (res_take) begin
					st_d = ttid_pkg::ST_IDLE;
				end
			end
			default: st_d = ttid_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (st_q != ttid_pkg::ST_IDLE);
		mem_re    = 1'b0;
		mem_raddr = r_q[ttid_pkg::IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = w_q[ttid_pkg::IDX_W-1:0];
		mem_wdata = rdata;
		res_valid = 1'b0;
		res       = res_q;
		case (st_q)
			ttid_pkg::ST_SET_RD, ttid_pkg::ST_CMP_RD, ttid_pkg::ST_QRY_RD: mem_re = 1'b1;
			ttid_pkg::ST_SET_WR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[ttid_pkg::IDX_W-1:0];
				mem_wdata = '{alarm: alarm_q, id: cand_q};
			end
			ttid_pkg::ST_CMP_EV: begin
				// compact survivors towards the front of the table
				mem_we = !drop;
				if (poll_q && drop && pend_q) begin
					res_valid = 1'b1;
					res = '0;
					res.result_id = pend_id_q;
					res.expired   = 1'b1;
				end
			end
			ttid_pkg::ST_EMIT: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ttid_pkg::ST_IDLE;
			cnt_q <= '0;
			ctr_q <= '0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			ctr_q <= ctr_d;
		end
	end

	always_ff @(posedge clk) begin
		r_q       <= r_d;
		w_q       <= w_d;
		n_q       <= n_d;
		cand_q    <= cand_d;
		pend_id_q <= pend_id_d;
		req_q     <= req_d;
		found_q   <= found_d;
		pend_q    <= pend_d;
		poll_q    <= poll_d;
		now_q     <= now_d;
		alarm_q   <= alarm_d;
		short_q   <= short_d;
		res_q     <= res_d;
	end

endmodule
`default_nettype wire

// ===== hdl/timer_table_with_id_allocation.sv =====
// Timer table with id allocation: top level with the result output register.
// One transaction in at a time. A set reads and evaluates every live entry
// for each id candidate tried, restarting the walk when the candidate is
// taken, and then writes the new entry; remove and poll read and evaluate
// every live entry, with each reported timer but the final one leaving during
// the walk and holding the walk only while the output is stalled; a query
// also reads and evaluates every live entry. The timer memory is read and
// evaluated one entry at a time. Results leave through an output register,
// so the next transaction is taken while the last result waits.
`default_nettype none
module timer_table_with_id_allocation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [47:0] now_ms,
	input  wire logic [31:0] delay_ms,
	input  wire logic [15:0] request_id,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [15:0]      result_id,
	output logic             expired,
	output logic signed [31:0] shortest_ms,
	output logic             last
);

	logic              res_valid, res_take, out_valid_q;
	ttid_pkg::result_t res, out_q;

	ttid_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.now_ms     (now_ms),
		.delay_ms   (delay_ms),
		.request_id (request_id),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take)
	);

	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign result_id   = out_q.result_id;
	assign expired     = out_q.expired;
	assign shortest_ms = out_q.shortest_ms;
	assign last        = out_q.last;

endmodule
`default_nettype wire
